// ===== src/pcac_pkg.sv =====
// shared types and constants for the per-class accuracy counter
// no dependencies; used by the controller, datapath, top level and checker
package pcac_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int COUNT_BITS  = 32;
   localparam int CLS_BITS    = $clog2(MAX_CLASSES);
   localparam int SLOT_BITS   = $clog2(MAX_CLASSES + 1);
   localparam int NCLS_BITS   = 5;
   localparam int PCT_BITS    = 15;
   localparam int PCT_SCALE   = 25600;
   localparam int PROD_BITS   = COUNT_BITS + PCT_BITS;
   localparam int STEP_BITS   = $clog2(PCT_BITS);
   localparam logic [NCLS_BITS-1:0] NCLS_RESET = NCLS_BITS'(2);

   typedef enum logic {
      CMD_COUNT  = 1'b0,
      CMD_REPORT = 1'b1
   } pcac_cmd_type;

   typedef struct packed {
      logic                cmd;
      logic [CLS_BITS-1:0] predicted_class;
      logic [CLS_BITS-1:0] true_class;
   } pcac_req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic [PCT_BITS-1:0]  accuracy_pct;
      logic                 empty_res;
      logic                 last;
   } pcac_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                 count;
      logic                 load;
      logic                 step;
      logic                 emit;
      logic                 last;
      logic                 clear;
      logic [SLOT_BITS-1:0] slot;
   } pcac_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } pcac_state_type;

endpackage

// ===== src/pcac_ctrl.sv =====
// report sequencer: walks the slots, runs the divider per slot, emits results;
// passes count words on as a count strobe; depends on pcac_pkg
module pcac_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           req_cmd,
   input  logic [pcac_pkg::SLOT_BITS-1:0] eff_classes,
   output logic                           busy,
   output pcac_pkg::pcac_ctl_type         ctl
);

   pcac_pkg::pcac_state_type state_ff, state_in;
   logic [pcac_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic [pcac_pkg::STEP_BITS-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcac_pkg::ST_IDLE;
         slot_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      step_in   = step_ff;
      ctl       = '0;
      ctl.slot  = slot_ff;
      busy      = (state_ff != pcac_pkg::ST_IDLE);
      case (state_ff)
         pcac_pkg::ST_IDLE: begin
            if (start) begin
               if (req_cmd == pcac_pkg::CMD_REPORT) begin
                  state_in = pcac_pkg::ST_LOAD;
                  slot_in  = '0;
               end else begin
                  ctl.count = 1'b1;
               end
            end
         end
         pcac_pkg::ST_LOAD: begin
            ctl.load = 1'b1;
            step_in  = '0;
            state_in = pcac_pkg::ST_DIV;
         end
         pcac_pkg::ST_DIV: begin
            ctl.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == pcac_pkg::STEP_BITS'(pcac_pkg::PCT_BITS - 1)) begin
               state_in = pcac_pkg::ST_EMIT;
            end
         end
         pcac_pkg::ST_EMIT: begin
            ctl.emit = 1'b1;
            if (slot_ff == eff_classes) begin
               // final slot: clear every counter as the result goes out
               ctl.last  = 1'b1;
               ctl.clear = 1'b1;
               state_in  = pcac_pkg::ST_IDLE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = pcac_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = pcac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/pcac_dpath.sv =====
// counters, class count register, scale multiply and bit-serial divider
// depends on pcac_pkg
module pcac_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pcac_pkg::pcac_ctl_type              ctl,
   input  pcac_pkg::pcac_req_type              req_word,
   input  logic                                csr_we,
   input  logic [pcac_pkg::NCLS_BITS-1:0]      csr_data,
   output logic [pcac_pkg::SLOT_BITS-1:0]      eff_classes,
   output logic                                rsp_valid,
   output pcac_pkg::pcac_rsp_type              rsp_word
);

   localparam int CB = pcac_pkg::COUNT_BITS;
   localparam int PB = pcac_pkg::PCT_BITS;
   localparam logic [CB-1:0] CNT_MAX = '1;

   logic [CB-1:0] total_ff   [pcac_pkg::MAX_CLASSES];
   logic [CB-1:0] correct_ff [pcac_pkg::MAX_CLASSES];
   logic [CB-1:0] hits_ff, samples_ff;
   logic [pcac_pkg::NCLS_BITS-1:0] ncls_ff;

   logic [CB-1:0] div_ff, rem_ff, rem_in;
   logic [PB-1:0] quo_ff, quo_in;
   logic          empty_ff;
   logic          rsp_valid_ff;
   pcac_pkg::pcac_rsp_type rsp_ff;

   logic [pcac_pkg::CLS_BITS-1:0]  tgt, cls_idx;
   logic                           in_range, hit;
   logic [CB-1:0]                  sel_hits, sel_total;
   logic [pcac_pkg::PROD_BITS-1:0] prod;
   logic [CB:0]                    trial;
   logic                           ge;

   always_comb begin
      if (ncls_ff == '0) begin
         eff_classes = pcac_pkg::SLOT_BITS'(1);
      end else if (pcac_pkg::SLOT_BITS'(ncls_ff) >
                   pcac_pkg::SLOT_BITS'(pcac_pkg::MAX_CLASSES)) begin
         eff_classes = pcac_pkg::SLOT_BITS'(pcac_pkg::MAX_CLASSES);
      end else begin
         eff_classes = pcac_pkg::SLOT_BITS'(ncls_ff);
      end
   end

   assign tgt      = req_word.true_class;
   assign in_range = pcac_pkg::SLOT_BITS'(tgt) < eff_classes;
   assign hit      = (req_word.predicted_class == tgt);

   // slot 0 is the overall figure, slot k is class k-1
   assign cls_idx = pcac_pkg::CLS_BITS'(ctl.slot - 1'b1);
   always_comb begin
      if (ctl.slot == '0) begin
         sel_hits  = hits_ff;
         sel_total = samples_ff;
      end else begin
         sel_hits  = correct_ff[cls_idx];
         sel_total = total_ff[cls_idx];
      end
   end

   assign prod = pcac_pkg::PROD_BITS'(sel_hits) *
                 pcac_pkg::PROD_BITS'(pcac_pkg::PCT_SCALE);

   // restoring division, one quotient bit per cycle; hits <= total keeps the
   // quotient within PCT_BITS, so the top part of the dividend starts below the divisor
   assign trial  = {rem_ff, quo_ff[PB-1]};
   assign ge     = (trial >= {1'b0, div_ff});
   assign rem_in = ge ? CB'(trial - {1'b0, div_ff}) : CB'(trial);
   assign quo_in = {quo_ff[PB-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < pcac_pkg::MAX_CLASSES; i++) begin
            total_ff[i]   <= '0;
            correct_ff[i] <= '0;
         end
         hits_ff    <= '0;
         samples_ff <= '0;
      end else if (ctl.count && in_range) begin
         if (total_ff[tgt] != CNT_MAX) total_ff[tgt] <= total_ff[tgt] + 1'b1;
         if (samples_ff != CNT_MAX) samples_ff <= samples_ff + 1'b1;
         if (hit) begin
            if (correct_ff[tgt] != CNT_MAX) correct_ff[tgt] <= correct_ff[tgt] + 1'b1;
            if (hits_ff != CNT_MAX) hits_ff <= hits_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncls_ff <= pcac_pkg::NCLS_RESET;
      end else if (csr_we) begin
         ncls_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rem_ff   <= prod[pcac_pkg::PROD_BITS-1:PB];
         quo_ff   <= prod[PB-1:0];
         div_ff   <= sel_total;
         empty_ff <= (sel_total == '0);
      end else if (ctl.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_ff.slot         <= ctl.slot;
         rsp_ff.accuracy_pct <= empty_ff ? '0 : quo_ff;
         rsp_ff.empty_res    <= empty_ff;
         rsp_ff.last         <= ctl.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== src/per_class_accuracy_counter.sv =====
// Per-class accuracy counter. A count word (cmd 0) is taken every cycle while
// busy is low; if its true class is in use it updates the counters in that
// cycle, and busy never rises for it. A report word (cmd 1) raises busy and
// produces one result for the overall accuracy and one per class in use, each
// shown for a single cycle on rsp_valid; every slot runs a 15-step bit-serial
// divider, and all counters are cleared with the last result. The receiver
// cannot stall, so results must be taken as they appear.
// depends on pcac_pkg, pcac_ctrl, pcac_dpath
module per_class_accuracy_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pcac_pkg::pcac_req_type              req_word,
   output logic                                rsp_valid,
   output pcac_pkg::pcac_rsp_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcac_pkg::NCLS_BITS-1:0]      csr_data
);

   pcac_pkg::pcac_ctl_type         ctl;
   logic [pcac_pkg::SLOT_BITS-1:0] eff_classes;

   assign csr_ready = 1'b1;

   pcac_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_cmd     (req_word.cmd),
      .eff_classes (eff_classes),
      .busy        (busy),
      .ctl         (ctl)
   );

   pcac_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_word    (req_word),
      .csr_we      (csr_valid & csr_ready),
      .csr_data    (csr_data),
      .eff_classes (eff_classes),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== src/pcac_checker.sv =====
// port-level checks for the per-class accuracy counter, bound to the top level
// depends on pcac_pkg
module pcac_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input pcac_pkg::pcac_req_type req_word,
   input logic                   rsp_valid,
   input pcac_pkg::pcac_rsp_type rsp_word
);

   // a report word always starts a run
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.cmd == pcac_pkg::CMD_REPORT |=> busy)
      else $error("report word did not raise busy");

   // only the final word of a run may appear once busy has dropped
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> busy)
      else $error("non-final word outside a report run");

   // each slot takes the divider's full run, so words never come back to back
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result words back to back");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_res |-> rsp_word.accuracy_pct == '0)
      else $error("empty slot with nonzero accuracy");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.accuracy_pct <= pcac_pkg::PCT_BITS'(pcac_pkg::PCT_SCALE))
      else $error("accuracy above full scale");

endmodule

bind per_class_accuracy_counter pcac_checker u_pcac_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
